FILE: src/lic_pkg.sv
// ----------------------------------------------------------------------------
// lic_pkg
// Shared types, codes and field widths of the lowest-id cluster router.
// ----------------------------------------------------------------------------
`default_nettype none

package lic_pkg;

    localparam int IN_W    = 144;  // packed input item, padded to whole bytes
    localparam int USER_W  = 3;
    localparam int OUT_W   = 72;   // packed result item, padded to whole bytes
    localparam int PADDR_W = 4;
    localparam int GEO_W   = 80;   // position (3 x 16) and last sighting time
    localparam int TAG_W   = 16;   // role, cluster and node-to-cluster map
    localparam int DIST_W  = 34;

    localparam logic [6:0] NO_CLUSTER = 7'd64;

    typedef enum logic [2:0] {
        CMD_SIGHT = 3'd0,
        CMD_PURGE = 3'd1,
        CMD_SHARE = 3'd2,
        CMD_ELECT = 3'd3,
        CMD_QUERY = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ROLE_UNDEC   = 2'd0,
        ROLE_HEAD    = 2'd1,
        ROLE_MEMBER  = 2'd2,
        ROLE_GATEWAY = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        REG_MY_ID   = 2'd0,
        REG_RANGE   = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_NONE    = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        SC_PURGE = 2'd0,
        SC_ELECT1 = 2'd1,
        SC_ELECT2 = 2'd2,
        SC_ROUTE = 2'd3
    } t_scan;

    typedef enum logic [1:0] {
        BUMP_NONE  = 2'd0,
        BUMP_INTRA = 2'd1,
        BUMP_INTER = 2'd2,
        BUMP_FAIL  = 2'd3
    } t_bump;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SG_RD, ST_SG_W1, ST_SG_W2, ST_SG_DO, ST_SH_RD, ST_SH_WR,
        ST_Q_RD, ST_Q_MAP, ST_SCAN, ST_DRAIN, ST_EL_MID, ST_EL_RD, ST_EL_WR,
        ST_Q_FIN, ST_DONE
    } t_state;

    typedef struct packed {
        logic [6:0] map;
        logic [6:0] clu;
        t_role      role;
    } t_tag;

    typedef struct packed {
        logic       ev;
        logic       stale;
        t_role      role;
        logic [6:0] clu;
    } t_meta;

endpackage

`default_nettype wire

FILE: src/lic_ram.sv
// ----------------------------------------------------------------------------
// lic_ram
// Single-port-write, single-port-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: src/lic_dist.sv
// ----------------------------------------------------------------------------
// lic_dist
// Three-stage squared Euclidean distance pipeline on signed 16-bit coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module lic_dist (
    input  wire logic                          i_clk,
    input  wire logic signed [15:0]            i_ax,
    input  wire logic signed [15:0]            i_ay,
    input  wire logic signed [15:0]            i_az,
    input  wire logic signed [15:0]            i_bx,
    input  wire logic signed [15:0]            i_by,
    input  wire logic signed [15:0]            i_bz,
    output logic             [lic_pkg::DIST_W-1:0] o_dist
);
    import lic_pkg::*;

    logic signed [16:0] r_dx, r_dy, r_dz;
    logic signed [33:0] sq_x, sq_y, sq_z;
    logic        [31:0] r_sx, r_sy, r_sz;

    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign sq_z = r_dz * r_dz;

    always_ff @(posedge i_clk) begin
        r_dx   <= {i_ax[15], i_ax} - {i_bx[15], i_bx};
        r_dy   <= {i_ay[15], i_ay} - {i_by[15], i_by};
        r_dz   <= {i_az[15], i_az} - {i_bz[15], i_bz};
        // A square of a 17-bit difference is below 2^32.
        r_sx   <= sq_x[31:0];
        r_sy   <= sq_y[31:0];
        r_sz   <= sq_z[31:0];
        o_dist <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
    end

endmodule

`default_nettype wire

FILE: src/lowest_id_cluster_router.sv
// ----------------------------------------------------------------------------
// lowest_id_cluster_router
// Neighbor table, lowest-id clustering and next-hop selection for one node.
// ----------------------------------------------------------------------------
// One item is worked at a time. Purge, election and route query scan the
// neighbor table through its single read port, one entry per cycle, followed
// by a 4-stage read and distance pipeline; an election makes a second pass for
// gateway detection when the node does not become head. A result waiting in the
// result register does not block the next item from being accepted, but that
// item's result waits until the register is free. The tables need no clearing
// pass after reset.
`default_nettype none

module lowest_id_cluster_router #(
    parameter int MAX_NODES = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // node_id, pos_x, pos_y, pos_z, self_x, self_y, self_z, now_time,
    // shared_role, shared_cluster, one pad bit
    input  wire logic [lic_pkg::IN_W-1:0]      s_axis_tdata,
    // command
    input  wire logic [lic_pkg::USER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // next_hop, route_found, own_role, own_cluster, neighbor_count,
    // intra_count, inter_count, failure_count, two pad bits
    output logic      [lic_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lic_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import lic_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_NODES - 1);

    // ---------------- configuration ----------------
    logic [5:0]  r_my;
    logic [15:0] r_range;
    logic [31:0] r_timeout;
    logic [31:0] r_range_sq;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my      <= '0;
            r_range   <= 16'd250;
            r_timeout <= 32'd3000;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_MY_ID:   r_my      <= pwdata[5:0];
                REG_RANGE:   r_range   <= pwdata[15:0];
                REG_TIMEOUT: r_timeout <= pwdata;
                REG_NONE:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_range_sq <= 32'(r_range) * 32'(r_range);
    end

    always_comb begin
        unique case (t_reg'(paddr[3:2]))
            REG_MY_ID:   prdata = {26'd0, r_my};
            REG_RANGE:   prdata = {16'd0, r_range};
            REG_TIMEOUT: prdata = r_timeout;
            REG_NONE:    prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    t_state r_state, n_state;
    t_scan  r_scan, n_scan;
    logic [MAX_NODES-1:0] r_valid;
    logic [MAX_NODES-1:0] r_mknown;
    logic [AW:0]          r_count;
    t_role                r_role;
    logic [6:0]           r_clu;
    logic [15:0]          r_intra, r_inter, r_fail;
    logic [4:1]           r_live;

    // captured item
    t_cmd               r_cmd;
    logic [5:0]         r_id;
    logic signed [15:0] r_px, r_py, r_pz, r_sx, r_sy, r_sz;
    logic [31:0]        r_now;
    t_role              r_srole;
    logic [6:0]         r_sclu;
    logic [6:0]         r_dc;
    logic [5:0]         r_hop;
    logic               r_found;

    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_idx [1:4];
    t_meta              r_meta [2:4];
    t_meta              meta1;

    // scan results
    logic               r_all_f, r_hg_f, r_own_f, r_fdc_f, r_fgw_f, r_fv_f, r_hd_f;
    logic [AW-1:0]      r_all_i, r_hg_i, r_own_i, r_fdc_i, r_fgw_i, r_fv_i, r_hd_i;
    logic [DIST_W-1:0]  r_all_d, r_hg_d, r_own_d;

    // control
    logic          in_acc, scan_go, scan_issue, out_load;
    logic          tag_re, tag_we, geo_we;
    logic [AW-1:0] tag_raddr, tag_waddr;
    t_tag          tag_wdata, tag_rdata;
    logic [GEO_W-1:0] geo_rdata;
    logic [DIST_W-1:0] sq_dist;
    logic signed [15:0] dax, day, daz;
    logic          sg_admit, el_head;

    function automatic logic in_tab(input logic [6:0] id);
        return 32'(id) < MAX_NODES;
    endfunction

    function automatic logic is_nb(input logic [6:0] id, input logic [MAX_NODES-1:0] vld);
        return in_tab(id) && vld[AW'(id)];
    endfunction

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ---------------- memories and distance unit ----------------
    lic_ram #(.DEPTH(MAX_NODES), .WIDTH(GEO_W)) u_geo (
        .i_clk   (i_clk),
        .i_we    (geo_we),
        .i_waddr (AW'(r_id)),
        .i_wdata ({r_now, r_pz, r_py, r_px}),
        .i_re    (scan_issue),
        .i_raddr (r_addr),
        .o_rdata (geo_rdata)
    );

    lic_ram #(.DEPTH(MAX_NODES), .WIDTH(TAG_W)) u_tag (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    // A sighting measures own position against the item; a scan measures
    // each stored position against the destination.
    assign dax = (r_cmd == CMD_SIGHT) ? r_sx : geo_rdata[15:0];
    assign day = (r_cmd == CMD_SIGHT) ? r_sy : geo_rdata[31:16];
    assign daz = (r_cmd == CMD_SIGHT) ? r_sz : geo_rdata[47:32];

    lic_dist u_dist (
        .i_clk  (i_clk),
        .i_ax   (dax),
        .i_ay   (day),
        .i_az   (daz),
        .i_bx   (r_px),
        .i_by   (r_py),
        .i_bz   (r_pz),
        .o_dist (sq_dist)
    );

    assign sg_admit = (r_id != r_my) && in_tab({1'b0, r_id}) &&
                      (sq_dist < DIST_W'(r_range_sq));
    assign el_head  = !r_fv_f || !(32'(r_fv_i) < 32'(r_my));

    always_comb begin
        meta1.ev    = r_valid[r_idx[1]];
        meta1.stale = (r_now - geo_rdata[79:48]) > r_timeout;
        meta1.role  = tag_rdata.role;
        meta1.clu   = tag_rdata.clu;
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        scan_go    = 1'b0;
        scan_issue = 1'b0;
        out_load   = 1'b0;
        tag_re     = 1'b0;
        tag_raddr  = AW'(r_id);
        tag_we     = 1'b0;
        tag_waddr  = AW'(r_id);
        tag_wdata  = tag_rdata;
        geo_we     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_cmd'(s_axis_tuser))
                        CMD_SIGHT: n_state = ST_SG_RD;
                        CMD_PURGE: begin
                            scan_go = 1'b1;
                            n_scan  = SC_PURGE;
                            n_state = ST_SCAN;
                        end
                        CMD_SHARE: n_state = ST_SH_RD;
                        CMD_ELECT: begin
                            scan_go = 1'b1;
                            n_scan  = SC_ELECT1;
                            n_state = ST_SCAN;
                        end
                        CMD_QUERY: n_state = ST_Q_RD;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_SG_RD: begin
                tag_re  = 1'b1;
                n_state = ST_SG_W1;
            end
            ST_SG_W1: n_state = ST_SG_W2;
            ST_SG_W2: n_state = ST_SG_DO;
            ST_SG_DO: begin
                if (sg_admit) begin
                    geo_we = 1'b1;
                    if (!r_valid[AW'(r_id)]) begin
                        tag_we         = 1'b1;
                        tag_wdata.role = ROLE_UNDEC;
                        tag_wdata.clu  = NO_CLUSTER;
                    end
                end
                n_state = ST_DONE;
            end
            ST_SH_RD: begin
                if (is_nb({1'b0, r_id}, r_valid)) begin
                    tag_re  = 1'b1;
                    n_state = ST_SH_WR;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SH_WR: begin
                tag_we    = 1'b1;
                tag_wdata = '{map: r_sclu, clu: r_sclu, role: r_srole};
                n_state   = ST_DONE;
            end
            ST_Q_RD: begin
                tag_re  = 1'b1;
                n_state = ST_Q_MAP;
            end
            ST_Q_MAP: begin
                scan_go = 1'b1;
                n_scan  = SC_ROUTE;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                scan_issue = 1'b1;
                tag_re     = 1'b1;
                tag_raddr  = r_addr;
                if (r_addr == LAST_ADDR) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_live == '0) begin
                    unique case (r_scan)
                        SC_PURGE:  n_state = ST_DONE;
                        SC_ELECT1: n_state = ST_EL_MID;
                        SC_ELECT2: n_state = ST_EL_RD;
                        SC_ROUTE:  n_state = ST_Q_FIN;
                    endcase
                end
            end
            ST_EL_MID: begin
                if (el_head) begin
                    n_state = ST_EL_RD;
                end else begin
                    scan_go = 1'b1;
                    n_scan  = SC_ELECT2;
                    n_state = ST_SCAN;
                end
            end
            ST_EL_RD: begin
                tag_raddr = AW'(r_my);
                if (in_tab({1'b0, r_my})) begin
                    tag_re  = 1'b1;
                    n_state = ST_EL_WR;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_EL_WR: begin
                tag_we        = 1'b1;
                tag_waddr     = AW'(r_my);
                tag_wdata.map = r_clu;
                n_state       = ST_DONE;
            end
            ST_Q_FIN: n_state = ST_DONE;
            ST_DONE: begin
                if (!m_axis_tvalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    // ---------------- route decision ----------------
    logic       sc_nb, dc_nb, mem_gw, dst_nb;
    logic       a_f, b_f;
    logic [5:0] a_h, b_h;
    logic       q_f;
    logic [5:0] q_h;
    t_bump      q_b;

    assign dst_nb = is_nb({1'b0, r_id}, r_valid);
    assign sc_nb  = is_nb(r_clu, r_valid);
    assign dc_nb  = is_nb(r_dc, r_valid);
    assign mem_gw = (r_role == ROLE_MEMBER) || (r_role == ROLE_GATEWAY);

    always_comb begin
        // Intra-cluster candidate.
        if (r_role == ROLE_HEAD) begin
            a_f = r_own_f;
            a_h = 6'(r_own_i);
        end else begin
            a_f = sc_nb;
            a_h = r_clu[5:0];
        end
        // Inter-cluster candidate.
        if (mem_gw) begin
            if (r_role == ROLE_GATEWAY && r_fdc_f) begin
                b_f = 1'b1;
                b_h = 6'(r_fdc_i);
            end else begin
                b_f = sc_nb;
                b_h = r_clu[5:0];
            end
        end else if (dc_nb) begin
            b_f = 1'b1;
            b_h = r_dc[5:0];
        end else if (r_fdc_f && r_fgw_f) begin
            b_f = 1'b1;
            b_h = 6'(r_fgw_i);
        end else begin
            b_f = r_hg_f;
            b_h = 6'(r_hg_i);
        end

        q_f = 1'b1;
        q_h = '0;
        q_b = BUMP_INTER;
        priority if (dst_nb) begin
            q_h = r_id;
            q_b = BUMP_NONE;
        end else if (r_dc != NO_CLUSTER && r_dc == r_clu && a_f) begin
            q_h = a_h;
            q_b = BUMP_INTRA;
        end else if (r_dc != NO_CLUSTER && r_dc != r_clu && b_f) begin
            q_h = b_h;
        end else if (mem_gw && sc_nb) begin
            q_h = r_clu[5:0];
        end else if (r_role == ROLE_HEAD && (r_hg_f || r_all_f)) begin
            q_h = r_hg_f ? 6'(r_hg_i) : 6'(r_all_i);
        end else begin
            q_f = 1'b0;
            q_b = BUMP_FAIL;
        end
    end

    // ---------------- control registers ----------------
    logic  p4;
    t_meta m4;
    logic [AW-1:0] k4;

    assign p4 = r_live[4];
    assign m4 = r_meta[4];
    assign k4 = r_idx[4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= '0;
            r_mknown      <= '0;
            r_count       <= '0;
            r_role        <= ROLE_UNDEC;
            r_clu         <= NO_CLUSTER;
            r_intra       <= '0;
            r_inter       <= '0;
            r_fail        <= '0;
            r_live        <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_live <= {r_live[3:1], scan_issue};

            if (r_state == ST_SG_DO && sg_admit && !r_valid[AW'(r_id)]) begin
                r_valid[AW'(r_id)] <= 1'b1;
                r_count            <= r_count + 1'b1;
            end
            if (p4 && r_scan == SC_PURGE && m4.ev && m4.stale) begin
                r_valid[k4] <= 1'b0;
                r_count     <= r_count - 1'b1;
            end
            if (p4 && r_scan == SC_ELECT2 && m4.ev && m4.clu != NO_CLUSTER &&
                m4.clu != r_clu) begin
                r_role <= ROLE_GATEWAY;
            end
            if (r_state == ST_SH_WR) begin
                r_mknown[AW'(r_id)] <= 1'b1;
            end
            if (r_state == ST_EL_WR) begin
                r_mknown[AW'(r_my)] <= 1'b1;
            end
            if (r_state == ST_EL_MID) begin
                if (el_head) begin
                    r_role <= ROLE_HEAD;
                    r_clu  <= {1'b0, r_my};
                end else begin
                    r_role <= ROLE_MEMBER;
                    r_clu  <= r_hd_f ? 7'(r_hd_i) : 7'(r_fv_i);
                end
            end
            if (r_state == ST_Q_FIN) begin
                unique case (q_b)
                    BUMP_INTRA: if (r_intra != 16'hFFFF) r_intra <= r_intra + 16'd1;
                    BUMP_INTER: if (r_inter != 16'hFFFF) r_inter <= r_inter + 16'd1;
                    BUMP_FAIL:  if (r_fail != 16'hFFFF) r_fail <= r_fail + 16'd1;
                    BUMP_NONE:  ;
                endcase
            end
            if (out_load) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_id    <= s_axis_tdata[5:0];
            r_px    <= s_axis_tdata[21:6];
            r_py    <= s_axis_tdata[37:22];
            r_pz    <= s_axis_tdata[53:38];
            r_sx    <= s_axis_tdata[69:54];
            r_sy    <= s_axis_tdata[85:70];
            r_sz    <= s_axis_tdata[101:86];
            r_now   <= s_axis_tdata[133:102];
            r_srole <= t_role'(s_axis_tdata[135:134]);
            r_sclu  <= (s_axis_tdata[142:136] > 7'd63) ? NO_CLUSTER
                                                        : s_axis_tdata[142:136];
            r_hop   <= '0;
            r_found <= 1'b0;
        end
        if (scan_go) begin
            r_scan  <= n_scan;
            r_addr  <= '0;
            r_all_f <= 1'b0;
            r_hg_f  <= 1'b0;
            r_own_f <= 1'b0;
            r_fdc_f <= 1'b0;
            r_fgw_f <= 1'b0;
            r_fv_f  <= 1'b0;
            r_hd_f  <= 1'b0;
        end else if (scan_issue) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_state == ST_Q_MAP) begin
            r_dc <= (in_tab({1'b0, r_id}) && r_mknown[AW'(r_id)]) ? tag_rdata.map
                                                                  : NO_CLUSTER;
        end

        r_idx[1]  <= r_addr;
        r_idx[2]  <= r_idx[1];
        r_idx[3]  <= r_idx[2];
        r_idx[4]  <= r_idx[3];
        r_meta[2] <= meta1;
        r_meta[3] <= r_meta[2];
        r_meta[4] <= r_meta[3];

        // Entries arrive in ascending id order, so a strict compare keeps the
        // lowest id on equal distance and the first hit is the lowest id.
        if (p4 && m4.ev) begin
            if (r_scan == SC_ROUTE) begin
                if (!r_all_f || sq_dist < r_all_d) begin
                    r_all_f <= 1'b1;
                    r_all_i <= k4;
                    r_all_d <= sq_dist;
                end
                if ((m4.role == ROLE_HEAD || m4.role == ROLE_GATEWAY) &&
                    (!r_hg_f || sq_dist < r_hg_d)) begin
                    r_hg_f <= 1'b1;
                    r_hg_i <= k4;
                    r_hg_d <= sq_dist;
                end
                if (m4.clu == r_clu && (!r_own_f || sq_dist < r_own_d)) begin
                    r_own_f <= 1'b1;
                    r_own_i <= k4;
                    r_own_d <= sq_dist;
                end
                if (m4.clu == r_dc && !r_fdc_f) begin
                    r_fdc_f <= 1'b1;
                    r_fdc_i <= k4;
                end
                if (m4.role == ROLE_GATEWAY && m4.clu == r_clu && !r_fgw_f) begin
                    r_fgw_f <= 1'b1;
                    r_fgw_i <= k4;
                end
            end
            if (r_scan == SC_ELECT1) begin
                if (!r_fv_f) begin
                    r_fv_f <= 1'b1;
                    r_fv_i <= k4;
                end
                if (m4.role == ROLE_HEAD && !r_hd_f) begin
                    r_hd_f <= 1'b1;
                    r_hd_i <= k4;
                end
            end
        end

        if (r_state == ST_Q_FIN) begin
            r_hop   <= q_f ? q_h : 6'd0;
            r_found <= q_f;
        end
        if (out_load) begin
            m_axis_tdata <= {2'b00, r_fail, r_inter, r_intra,
                             (32'(r_count) > 63) ? 6'd63 : 6'(r_count),
                             r_clu, r_role, r_found, r_hop};
        end
    end

endmodule

`default_nettype wire

FILE: src/lowest_id_cluster_router_chk.sv
// ----------------------------------------------------------------------------
// lowest_id_cluster_router_chk
// Port-level checks on the result stream of the cluster router.
// ----------------------------------------------------------------------------
`default_nettype none

module lowest_id_cluster_router_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [lic_pkg::OUT_W-1:0]     m_axis_tdata
);
    import lic_pkg::*;

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A failed or non-query item reports hop zero.
    a_hop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[6] |-> m_axis_tdata[5:0] == 6'd0)
        else $error("hop set without a route");

    // Own role is undecided exactly while no cluster is held.
    a_role_cluster: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[8:7] == ROLE_UNDEC) == (m_axis_tdata[15:9] == NO_CLUSTER)))
        else $error("own role and cluster disagree");

endmodule

bind lowest_id_cluster_router lowest_id_cluster_router_chk u_chk (.*);

`default_nettype wire
